@@ src/bnms_pkg.sv @@
// Package for the box suppression unit: field structs, state codes, constants.
// No dependencies.
package bnms_pkg;

  localparam int MaxBoxesDefault = 64;
  localparam logic [15:0] IouResetValue = 16'd26214;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic signed [15:0] right_x;
    logic signed [15:0] bottom_y;
    logic [15:0]        score;
    logic [15:0]        tag;
    logic               batch_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] kept_left_x;
    logic signed [15:0] kept_top_y;
    logic signed [15:0] kept_right_x;
    logic signed [15:0] kept_bottom_y;
    logic [15:0]        kept_score;
    logic [15:0]        kept_tag;
    logic               final_kept;
  } out_beat_t;

  // box as held in one cell
  typedef struct packed {
    logic signed [15:0] lx;
    logic signed [15:0] ty;
    logic signed [15:0] rx;
    logic signed [15:0] by;
    logic [15:0]        score;
    logic [15:0]        tag;
  } box_t;

  // control broadcast from sequencer to cells
  typedef struct packed {
    logic load;    // insert incoming box into sorted chain
    logic shift;   // pop head, shift chain toward head
    logic cmp;     // compare head box against every cell, latch suppression
    logic clear;   // drop all entries
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CMP,
    ST_IOU,
    ST_EMIT,
    ST_WAIT
  } state_t;

endpackage

@@ src/bnms_cell.sv @@
// One chain cell: holds a box, keeps the chain sorted on insert, and runs
// the overlap test against the broadcast head box. Depends on bnms_pkg.
module bnms_cell
  import bnms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_ctl_t   ctl,
  input  box_t        new_box,
  input  logic [15:0] thr,
  input  box_t        head_box,
  input  box_t        prev_box,   // neighbor toward head
  input  logic        prev_valid,
  input  logic        prev_goes,  // neighbor toward head moves down on insert
  input  box_t        next_box,   // neighbor toward tail
  input  logic        next_valid,
  input  logic        next_sup,
  output box_t        box_o,
  output logic        valid_o,
  output logic        sup_o,
  output logic        goes_o
);

  box_t               box_r;
  logic               valid_r, sup_r;
  logic signed [16:0] iw, ih, wa, ha, wb, hb;
  logic signed [16:0] min_r, max_l, min_b, max_t;
  logic signed [33:0] inter_r, area_a_r, area_b_r;
  logic signed [35:0] uni;
  logic               hit_en_r, hit;
  logic [49:0]        lhs;
  logic [51:0]        rhs;
  logic               pos_inter;

  // insert: new box goes behind all equal or higher scores
  assign goes_o = valid_r && (box_r.score < new_box.score);

  // stage 1 of overlap: three products registered
  always_comb begin
    min_r = (head_box.rx < box_r.rx) ? 17'(head_box.rx) : 17'(box_r.rx);
    max_l = (head_box.lx > box_r.lx) ? 17'(head_box.lx) : 17'(box_r.lx);
    min_b = (head_box.by < box_r.by) ? 17'(head_box.by) : 17'(box_r.by);
    max_t = (head_box.ty > box_r.ty) ? 17'(head_box.ty) : 17'(box_r.ty);
    iw = min_r - max_l;
    ih = min_b - max_t;
    if (iw < 0) iw = '0;
    if (ih < 0) ih = '0;
    wa = 17'(head_box.rx) - 17'(head_box.lx);
    ha = 17'(head_box.by) - 17'(head_box.ty);
    wb = 17'(box_r.rx) - 17'(box_r.lx);
    hb = 17'(box_r.by) - 17'(box_r.ty);
  end

  always_ff @(posedge clk) begin
    inter_r  <= iw * ih;
    area_a_r <= wa * ha;
    area_b_r <= wb * hb;
  end

  // stage 2: union and compare, shift by 16 is free, one 36x16 product
  always_comb begin
    uni = 36'(area_a_r) + 36'(area_b_r) - 36'(inter_r);
    pos_inter = ~inter_r[33];
    lhs = {inter_r[33:0], 16'd0};
    rhs = 52'(uni[35:0]) * 52'(thr);
    hit = (uni > 0) && pos_inter && (52'(lhs) > rhs);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      sup_r    <= 1'b0;
      hit_en_r <= 1'b0;
    end else begin
      hit_en_r <= ctl.cmp;
      if (ctl.clear) begin
        valid_r <= 1'b0;
        sup_r   <= 1'b0;
      end else if (ctl.load) begin
        if (prev_goes) begin
          box_r   <= prev_box;
          valid_r <= prev_valid;
          sup_r   <= 1'b0;
        end else if (goes_o || (!valid_r && (prev_valid || !prev_valid))) begin
          if (goes_o || !valid_r) begin
            // first cell (from head) that is free or outranked takes new box
            if (!valid_r && !prev_valid) begin
              valid_r <= valid_r;
            end else begin
              box_r   <= new_box;
              valid_r <= 1'b1;
              sup_r   <= 1'b0;
            end
          end
        end
      end else if (ctl.shift) begin
        box_r   <= next_box;
        valid_r <= next_valid;
        sup_r   <= next_sup;
      end else if (hit_en_r && valid_r && hit) begin
        sup_r <= 1'b1;
      end
    end
  end

  assign box_o   = box_r;
  assign valid_o = valid_r;
  assign sup_o   = sup_r;

endmodule

@@ src/bnms_chain.sv @@
// Row of MAX_BOXES cells forming a sorted shift chain. Depends on bnms_pkg
// and bnms_cell.
module bnms_chain
  import bnms_pkg::*;
#(
  parameter int MAX_BOXES = MaxBoxesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_ctl_t   ctl,
  input  box_t        new_box,
  input  logic [15:0] thr,
  output box_t        head_box,
  output logic        head_valid,
  output logic        head_sup
);

  box_t [MAX_BOXES-1:0] box_w;
  logic [MAX_BOXES-1:0] valid_w, sup_w, goes_w;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    box_t pb, nb;
    logic pv, pg, nv, ns;
    if (i == 0) begin : g_first
      // virtual head neighbor is always valid and never yields
      assign pb = new_box;
      assign pv = 1'b1;
      assign pg = 1'b0;
    end else begin : g_mid
      assign pb = box_w[i-1];
      assign pv = valid_w[i-1];
      assign pg = goes_w[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_last
      assign nb = box_w[i];
      assign nv = 1'b0;
      assign ns = 1'b0;
    end else begin : g_tail
      assign nb = box_w[i+1];
      assign nv = valid_w[i+1];
      assign ns = sup_w[i+1];
    end
    bnms_cell u_cell (
      .clk(clk), .rst_n(rst_n), .ctl(ctl), .new_box(new_box), .thr(thr),
      .head_box(box_w[0]), .prev_box(pb), .prev_valid(pv), .prev_goes(pg),
      .next_box(nb), .next_valid(nv), .next_sup(ns),
      .box_o(box_w[i]), .valid_o(valid_w[i]), .sup_o(sup_w[i]), .goes_o(goes_w[i])
    );
  end

  assign head_box   = box_w[0];
  assign head_valid = valid_w[0];
  assign head_sup   = sup_w[0];

endmodule

@@ src/box_non_max_suppression_unit.sv @@
// Greedy NMS over a batch held in a sorted chain of cells.
// Load: boxes enter only in ST_LOAD, each inserted into its sorted place on entry.
// Closing: each kept box takes a compare, the 2-stage overlap test and a pop; each
// suppressed box takes only a pop; a final pass sends the last kept box and clears
// the chain. Output stalls hold the closing steps.
// Reset (rst_n sync, low): chain empty, threshold 26214, no output pending.
module box_non_max_suppression_unit
  import bnms_pkg::*;
#(
  parameter int MAX_BOXES = MaxBoxesDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int CW = $clog2(MAX_BOXES + 1);

  state_t      state_r, state_nxt;
  logic [15:0] thr_r;
  logic [CW-1:0] count_r, count_nxt;
  cell_ctl_t   ctl;
  box_t        new_box, head_box;
  logic        head_valid, head_sup, in_acc, out_acc, closing_r, closing_nxt;
  logic        have_kept_r, have_kept_nxt, load_ok;
  out_beat_t   out_r;
  logic        out_valid_r;
  box_t        pend_r;
  logic        pend_valid_r, pend_valid_nxt, pend_load;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= IouResetValue;
    else if (cfg_valid) thr_r <= cfg_data;
  end

  assign new_box = '{lx: in_data.left_x, ty: in_data.top_y, rx: in_data.right_x,
                     by: in_data.bottom_y, score: in_data.score, tag: in_data.tag};

  bnms_chain #(.MAX_BOXES(MAX_BOXES)) u_chain (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .new_box(new_box), .thr(thr_r),
    .head_box(head_box), .head_valid(head_valid), .head_sup(head_sup)
  );

  assign in_stall = (state_r != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign load_ok  = (count_r < CW'(MAX_BOXES));

  // Pending kept box: held one beat back so the last one can carry final_kept.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ctl            = '0;
    closing_nxt    = closing_r;
    have_kept_nxt  = have_kept_r;
    pend_valid_nxt = pend_valid_r;
    pend_load      = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (load_ok) begin
            ctl.load  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (in_data.batch_end) state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!head_valid) begin
          state_nxt = ST_EMIT;
          closing_nxt = 1'b1;
        end else if (head_sup) begin
          ctl.shift = 1'b1;
        end else begin
          ctl.cmp   = 1'b1;
          state_nxt = ST_IOU;
        end
      end
      ST_IOU: begin
        // overlap result lands at end of this cycle
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        // hand pending box to output; unless closing, take head as new pending
        if (!out_valid_r || out_acc) begin
          if (closing_r) begin
            state_nxt = ST_WAIT;
          end else begin
            pend_load      = 1'b1;
            pend_valid_nxt = 1'b1;
            have_kept_nxt  = 1'b1;
            ctl.shift      = 1'b1;
            state_nxt      = ST_CMP;
          end
        end
      end
      ST_WAIT: begin
        if (!out_valid_r || out_acc) begin
          ctl.clear      = 1'b1;
          count_nxt      = '0;
          closing_nxt    = 1'b0;
          have_kept_nxt  = 1'b0;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  logic push_out, push_final;
  assign push_out   = pend_valid_r && ((state_r == ST_EMIT) && (!out_valid_r || out_acc));
  assign push_final = closing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      closing_r    <= 1'b0;
      have_kept_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      closing_r    <= closing_nxt;
      have_kept_r  <= have_kept_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (push_out) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) pend_r <= head_box;
    if (push_out) begin
      out_r.kept_left_x   <= pend_r.lx;
      out_r.kept_top_y    <= pend_r.ty;
      out_r.kept_right_x  <= pend_r.rx;
      out_r.kept_bottom_y <= pend_r.by;
      out_r.kept_score    <= pend_r.score;
      out_r.kept_tag      <= pend_r.tag;
      out_r.final_kept    <= push_final;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a batch never closes with no kept box
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> have_kept_r) else $error("empty batch closed");
  // input is held off outside loading
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> in_stall) else $error("input open while busy");
  // fill count never exceeds chain length
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BOXES)) else $error("count overflow");
  // chain empty after a batch finishes
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(closing_r) |-> (count_r == '0)) else $error("count not cleared");

endmodule
